// ----- src/whrc_pkg.sv -----
`default_nettype none

package whrc_pkg;

    localparam int NUM_TYPES_DEF     = 7;
    localparam int HISTORY_DEPTH_DEF = 64;

    // Width that holds any bucket count up to the largest history depth.
    localparam int CNT_W = 9;

    localparam logic [1:0] CFG_BUCKET_PERIOD = 2'd0;
    localparam logic [1:0] CFG_MAX_BUCKETS   = 2'd1;
    localparam logic [1:0] CFG_START_TIME    = 2'd2;

    localparam logic FUNC_HIT   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic        func;
        logic [2:0]  category;
        logic [31:0] now;
        logic [6:0]  window;
    } req_t;

    typedef struct packed {
        logic [31:0] hit_total;
        logic [2:0]  category_out;
    } rsp_t;

endpackage

`default_nettype wire

// ----- src/whrc_ram.sv -----
`default_nettype none

module whrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 448
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output      logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/windowed_hit_rate_counter.sv -----
`default_nettype none

// Per-type hit counter with time buckets. A request is taken when start is high and busy is
// low; busy stays high until the request is finished. Each request first catches up the bucket
// rotation: every rotation copies all NUM_TYPES current buckets into the history memory, one
// type per cycle, and up to max_buckets rotations (at least one, at most HISTORY_DEPTH) may
// run. A hit then finishes in the same cycle as the last rotation check. A query reads one
// history entry per cycle from the history memory, k entries in all, with k equal to
// min(window, filled buckets) for a known type and zero otherwise, and presents its result for
// exactly one cycle on result with result_valid; the receiver cannot stall it. Hits never
// produce a result. Configuration is written through cfg_write; the user must write it only
// while the block is idle, and the block itself does not enforce this.
module windowed_hit_rate_counter import whrc_pkg::*; #(
    parameter int NUM_TYPES     = NUM_TYPES_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire req_t        request,
    output      logic        result_valid,
    output      rsp_t        result,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int TYPE_W    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int SLOT_W    = $clog2(HISTORY_DEPTH);
    localparam int FILL_W    = $clog2(HISTORY_DEPTH + 1);
    localparam int RAM_DEPTH = NUM_TYPES * (2 ** SLOT_W);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_PUSH  = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;

    logic [2:0]        state_reg, state_next;
    req_t              req_reg, req_next;
    logic [31:0]       period_reg;
    logic [6:0]        maxb_reg;
    logic [31:0]       last_rot_reg, last_rot_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [FILL_W-1:0] filled_reg, filled_next;
    logic [FILL_W-1:0] rot_cnt_reg, rot_cnt_next;
    logic [TYPE_W-1:0] t_reg, t_next;
    logic [SLOT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [FILL_W-1:0] remain_reg, remain_next;
    logic              pend_reg, pend_next;
    logic [31:0]       acc_reg, acc_next;
    logic              result_valid_reg, result_valid_next;
    rsp_t              result_reg, result_next;
    logic [31:0]       cur_reg [NUM_TYPES];

    logic              cur_we;
    logic [TYPE_W-1:0] cur_sel;
    logic [31:0]       cur_wdata;
    logic [31:0]       cur_rd;

    logic [CNT_W-1:0]  eff_wide;
    logic [FILL_W-1:0] eff_max;
    logic [CNT_W-1:0]  win_wide;
    logic [CNT_W-1:0]  fill_wide;
    logic [CNT_W-1:0]  k_wide;
    logic [3:0]        type_ext;
    logic [TYPE_W-1:0] type_idx;
    logic              known;
    logic [31:0]       diff;
    logic              rotate;
    logic [SLOT_W-1:0] rd_prev;
    logic [32:0]       sum_wide;

    logic                     ram_we;
    logic [TYPE_W+SLOT_W-1:0] waddr_full;
    logic [TYPE_W+SLOT_W-1:0] raddr_full;
    logic [31:0]              ram_rdata;

    whrc_ram #(
        .WIDTH(32),
        .DEPTH(RAM_DEPTH)
    ) u_history (
        .clk  (clk),
        .we   (ram_we),
        .waddr(waddr_full[RAM_AW-1:0]),
        .wdata(cur_rd),
        .raddr(raddr_full[RAM_AW-1:0]),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        eff_wide = {2'b00, maxb_reg};
        if (eff_wide == '0)
        begin
            eff_wide = CNT_W'(1);
        end
        if (eff_wide > CNT_W'(HISTORY_DEPTH))
        begin
            eff_wide = CNT_W'(HISTORY_DEPTH);
        end
        eff_max = eff_wide[FILL_W-1:0];
    end

    assign type_ext   = {1'b0, req_reg.category};
    assign type_idx   = type_ext[TYPE_W-1:0];
    assign known      = ({2'b00, req_reg.category} < 5'(NUM_TYPES));
    assign diff       = req_reg.now - last_rot_reg;
    assign rotate     = (rot_cnt_reg < eff_max) && (last_rot_reg < req_reg.now)
                        && (diff > period_reg);
    assign win_wide   = {2'b00, req_reg.window};
    assign fill_wide  = CNT_W'(filled_reg);
    assign k_wide     = (win_wide < fill_wide) ? win_wide : fill_wide;
    assign rd_prev    = (rd_idx_reg == '0) ? SLOT_W'(HISTORY_DEPTH - 1) : rd_idx_reg - 1'b1;
    assign sum_wide   = {1'b0, acc_reg} + {1'b0, ram_rdata};
    assign cur_sel    = (state_reg == ST_PUSH) ? t_reg : type_idx;
    assign cur_rd     = cur_reg[cur_sel];
    assign ram_we     = (state_reg == ST_PUSH);
    assign waddr_full = {t_reg, head_reg};
    assign raddr_full = {type_idx, rd_prev};

    always_comb
    begin
        state_next        = state_reg;
        req_next          = req_reg;
        last_rot_next     = last_rot_reg;
        head_next         = head_reg;
        filled_next       = filled_reg;
        rot_cnt_next      = rot_cnt_reg;
        t_next            = t_reg;
        rd_idx_next       = rd_idx_reg;
        remain_next       = remain_reg;
        pend_next         = 1'b0;
        acc_next          = acc_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        cur_we            = 1'b0;
        cur_wdata         = cur_rd;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next     = request;
                    rot_cnt_next = '0;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (rotate)
                begin
                    t_next     = '0;
                    state_next = ST_PUSH;
                end
                else if (req_reg.func == FUNC_HIT)
                begin
                    if (known && (cur_rd != 32'hFFFF_FFFF))
                    begin
                        cur_we    = 1'b1;
                        cur_wdata = cur_rd + 32'd1;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    remain_next = known ? k_wide[FILL_W-1:0] : '0;
                    rd_idx_next = head_reg;
                    acc_next    = '0;
                    state_next  = ST_SUM;
                end
            end
            ST_PUSH:
            begin
                cur_we    = 1'b1;
                cur_wdata = '0;
                if (t_reg == TYPE_W'(NUM_TYPES - 1))
                begin
                    head_next     = (head_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                    : head_reg + 1'b1;
                    filled_next   = (filled_reg < eff_max) ? filled_reg + 1'b1 : filled_reg;
                    last_rot_next = last_rot_reg + period_reg;
                    rot_cnt_next  = rot_cnt_reg + 1'b1;
                    state_next    = ST_CHECK;
                end
                else
                begin
                    t_next = t_reg + 1'b1;
                end
            end
            ST_SUM:
            begin
                if (pend_reg)
                begin
                    acc_next = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
                end
                if (remain_reg != '0)
                begin
                    rd_idx_next = rd_prev;
                    remain_next = remain_reg - 1'b1;
                    pend_next   = 1'b1;
                end
                else if (!pend_reg)
                begin
                    result_next.hit_total    = acc_reg;
                    result_next.category_out = req_reg.category;
                    result_valid_next        = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write && (cfg_index == CFG_START_TIME))
        begin
            last_rot_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            period_reg       <= 32'd60;
            maxb_reg         <= 7'd64;
            last_rot_reg     <= '0;
            head_reg         <= '0;
            filled_reg       <= '0;
            rot_cnt_reg      <= '0;
            t_reg            <= '0;
            remain_reg       <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                cur_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            filled_reg       <= filled_next;
            rot_cnt_reg      <= rot_cnt_next;
            t_reg            <= t_next;
            remain_reg       <= remain_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
            last_rot_reg     <= last_rot_next;
            if (cur_we)
            begin
                cur_reg[cur_sel] <= cur_wdata;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_BUCKET_PERIOD: period_reg <= cfg_data;
                    CFG_MAX_BUCKETS:   maxb_reg   <= cfg_data[6:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rd_idx_reg <= rd_idx_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_result_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($past(state_reg) == ST_SUM))
        else $error("result strobe without a finished window sum");

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(filled_reg) <= CNT_W'(HISTORY_DEPTH))
        else $error("filled bucket count exceeds history depth");

    a_read_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SUM))
        else $error("history read pending outside the window sum");

endmodule

`default_nettype wire
